/* rtl/pls_pkg.sv */
// ============================================================================
// pls_pkg: shared constants, types and helpers of the palette line scaler
// Output geometry, palette shape and the fixed-point step calculation.
// ============================================================================
package pls_pkg;

    localparam int OUT_WIDTH        = 320;
    localparam int OUT_HEIGHT       = 240;
    localparam int BLOCK_ROWS       = 64;
    localparam int MAX_SOURCE_WIDTH = 1024;

    localparam int SRC_W    = $clog2(MAX_SOURCE_WIDTH);  // source counter and width
    localparam int COL_W    = 9;
    localparam int LINE_W   = 8;
    localparam int BLK_W    = 2;
    localparam int ROW_W    = 6;
    localparam int COLOR_W  = 16;
    localparam int POS_W    = 18;                        // 10.8 position, 10 integer bits
    localparam int CMP_W    = 12;                        // headroom for compares
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_ADDR_W = $clog2(PAL_DEPTH);

    localparam logic [SRC_W-1:0] SRC_COUNT_MAX = {SRC_W{1'b1}};
    localparam logic [SRC_W-1:0] SRC_WIDTH_RST = SRC_W'(320);

    // step = (width * 256) / OUT_WIDTH by reciprocal multiply; exact for
    // numerators below 2^POS_W and OUT_WIDTH up to 1024
    localparam int STEP_SHIFT  = 28;
    localparam int STEP_RECIP  = ((2 ** STEP_SHIFT) + OUT_WIDTH - 1) / OUT_WIDTH;
    localparam int STEP_PROD_W = POS_W + STEP_SHIFT;

    // register map, word index
    typedef enum logic {
        REG_SOURCE_WIDTH = 1'b0,
        REG_USE_PALETTE  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                  en;
        logic [PAL_ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]    data;
    } pal_wr_t;

    function automatic logic [POS_W-1:0] step_of(input logic [SRC_W-1:0] width);
        logic [STEP_PROD_W-1:0] num;
        logic [STEP_PROD_W-1:0] prod;
        num  = STEP_PROD_W'({width, 8'h00});
        prod = num * STEP_PROD_W'(STEP_RECIP);
        return prod[STEP_SHIFT +: POS_W];
    endfunction

endpackage

/* rtl/palette_line_scaler.sv */
// ============================================================================
// palette_line_scaler: palette lookup and nearest-neighbour line scaler
// Turns source pixels of a line into frame-buffer writes (block, row,
// column, colour), downscaling, pixel-doubling or centring per line width.
// ============================================================================
// Usage
//   s_* channel: valid/ready. kind 0 is a palette write (slot <- pixel), no
//   result. kind 1 is a source pixel; first marks the start of a line and
//   latches its destination line.
//   m_* channel: valid/ready frame-buffer writes; last flags the final write
//   produced by a pixel. A pixel gives none, one or two writes.
//   APB port: reg 0 (addr 0) source_width, reg 1 (addr 4) use_palette.
//   Write only while the block is idle; a change applies from the next pixel.
// Path: palette read and holding stage load at the accept edge; the output
//   register, which drives m_valid, loads from the holding stage when free.
// Throughput: one item per cycle for palette writes and single-write pixels
//   while m_ready holds; a doubled pixel holds the holding stage until its
//   second write loads, so s_ready waits. The output register is the limit.
// Reset (synchronous, aresetn low): counters and line cleared, source_width
//   320, use_palette 1, channels empty. Palette contents are undefined.
// Receiver stall: the output register holds its transfer; the holding stage
//   behind it takes one more pixel, then s_ready drops.
// ============================================================================
module palette_line_scaler (
    input  logic                              aclk,
    input  logic                              aresetn,
    // source items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic                              s_first,
    input  logic [pls_pkg::LINE_W-1:0]        s_line,
    input  logic [pls_pkg::PAL_ADDR_W-1:0]    s_palette_slot,
    input  logic [pls_pkg::COLOR_W-1:0]       s_pixel,
    // frame-buffer writes
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pls_pkg::BLK_W-1:0]         m_frame_block,
    output logic [pls_pkg::ROW_W-1:0]         m_block_row,
    output logic [pls_pkg::COL_W-1:0]         m_column,
    output logic [pls_pkg::COLOR_W-1:0]       m_color,
    output logic                              m_last,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import pls_pkg::*;

    // ---------------------------------------------------------------- config
    logic [SRC_W-1:0] src_width_reg;
    logic             use_pal_reg;
    logic [POS_W-1:0] step_reg;      // precomputed 10.8 downscale step
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg <= SRC_WIDTH_RST;
            use_pal_reg   <= 1'b1;
            step_reg      <= step_of(SRC_WIDTH_RST);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SOURCE_WIDTH: begin
                    src_width_reg <= pwdata[SRC_W-1:0];
                    step_reg      <= step_of(pwdata[SRC_W-1:0]);
                end
                REG_USE_PALETTE: begin
                    use_pal_reg <= pwdata[0];
                end
                default: ;
            endcase
        end
    end

    // misaligned reads return zero
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (cfg_idx)
                REG_SOURCE_WIDTH: prdata = 32'(src_width_reg);
                REG_USE_PALETTE:  prdata = 32'(use_pal_reg);
                default:          prdata = '0;
            endcase
        end
    end

    // ---------------------------------------------------------------- intake
    logic s_acc;
    logic pix_acc;

    assign s_acc   = s_valid && s_ready;
    assign pix_acc = s_acc && s_kind;

    // palette: writes at accept, reads for every accepted pixel
    pal_wr_t            pal_wr;
    logic [COLOR_W-1:0] pal_rd_data;

    assign pal_wr.en   = s_acc && !s_kind;
    assign pal_wr.addr = s_palette_slot;
    assign pal_wr.data = s_pixel;

    pls_palette_ram u_palette (
        .aclk    (aclk),
        .wr      (pal_wr),
        .rd_en   (pix_acc),
        .rd_addr (s_pixel[PAL_ADDR_W-1:0]),
        .rd_data (pal_rd_data)
    );

    // ---------------------------------------------------------------- position tracking
    logic [SRC_W-1:0]  src_count_reg;
    logic [COL_W-1:0]  out_count_reg;
    logic [POS_W-1:0]  scale_pos_reg;
    logic [LINE_W-1:0] cur_line_reg;

    // state as seen by this pixel (a line start clears the counters, takes s_line)
    logic [SRC_W-1:0]  sc_eff;
    logic [COL_W-1:0]  oc_eff;
    logic [POS_W-1:0]  pos_eff;
    logic [LINE_W-1:0] line_eff;

    logic              in_range, line_ok, mode_down, mode_dbl, hit, advance, emit;
    logic [CMP_W-1:0]  centre_col;
    logic [COL_W-1:0]  col_first;

    always_comb begin
        sc_eff   = s_first ? '0     : src_count_reg;
        oc_eff   = s_first ? '0     : out_count_reg;
        pos_eff  = s_first ? '0     : scale_pos_reg;
        line_eff = s_first ? s_line : cur_line_reg;

        in_range  = sc_eff < src_width_reg;
        line_ok   = CMP_W'(line_eff) < CMP_W'(OUT_HEIGHT);
        mode_down = CMP_W'(src_width_reg) > CMP_W'(OUT_WIDTH);
        mode_dbl  = {CMP_W'(src_width_reg), 1'b0} == (CMP_W + 1)'(OUT_WIDTH);
        hit       = (CMP_W'(oc_eff) < CMP_W'(OUT_WIDTH)) && (pos_eff[POS_W-1:8] == sc_eff);

        advance = in_range && line_ok && mode_down && hit;
        emit    = in_range && line_ok && (!mode_down || hit);

        centre_col = ((CMP_W'(OUT_WIDTH) - CMP_W'(src_width_reg)) >> 1) + CMP_W'(sc_eff);

        priority if (mode_down) begin
            col_first = oc_eff;
        end else if (mode_dbl) begin
            col_first = {sc_eff[COL_W-2:0], 1'b0};
        end else begin
            col_first = centre_col[COL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_count_reg <= '0;
            out_count_reg <= '0;
            scale_pos_reg <= '0;
            cur_line_reg  <= '0;
        end else if (pix_acc) begin
            src_count_reg <= (sc_eff != SRC_COUNT_MAX) ? sc_eff + SRC_W'(1) : sc_eff;
            out_count_reg <= advance ? oc_eff + COL_W'(1) : oc_eff;
            scale_pos_reg <= advance ? pos_eff + step_reg : pos_eff;
            cur_line_reg  <= line_eff;
        end
    end

    // ---------------------------------------------------------------- holding stage
    // One pixel that owes writes; its palette colour sits in the RAM read
    // register, which only moves when the next pixel is taken.
    logic               s1_valid_reg;
    logic               s1_phase_reg;    // second write of a doubled pixel
    logic               s1_dbl_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [LINE_W-1:0]  s1_line_reg;
    logic               s1_use_pal_reg;
    logic [COLOR_W-1:0] s1_pixel_reg;

    logic out_load;
    logic s1_leave;

    assign out_load = s1_valid_reg && (!m_valid || m_ready);
    assign s1_leave = out_load && (!s1_dbl_reg || s1_phase_reg);
    assign s_ready  = !s1_valid_reg || s1_leave;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
        end else begin
            if (pix_acc && emit) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_leave) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load && s1_dbl_reg && !s1_phase_reg) begin
                s1_phase_reg <= 1'b1;
            end else if (s1_leave) begin
                s1_phase_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_acc && emit) begin
            s1_dbl_reg     <= mode_dbl && !mode_down;
            s1_col_reg     <= col_first;
            s1_line_reg    <= line_eff;
            s1_use_pal_reg <= use_pal_reg;
            s1_pixel_reg   <= s_pixel;
        end
    end

    // ---------------------------------------------------------------- output register
    logic               m_valid_reg;
    logic [BLK_W-1:0]   m_frame_block_reg;
    logic [ROW_W-1:0]   m_block_row_reg;
    logic [COL_W-1:0]   m_column_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic               m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_frame_block_reg <= BLK_W'(s1_line_reg / BLOCK_ROWS);
            m_block_row_reg   <= ROW_W'(s1_line_reg % BLOCK_ROWS);
            m_column_reg      <= s1_col_reg + COL_W'(s1_phase_reg);
            m_color_reg       <= s1_use_pal_reg ? pal_rd_data : s1_pixel_reg;
            m_last_reg        <= !s1_dbl_reg || s1_phase_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_frame_block = m_frame_block_reg;
    assign m_block_row   = m_block_row_reg;
    assign m_column      = m_column_reg;
    assign m_color       = m_color_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    // second-write phase only ever belongs to a held doubled pixel
    a_phase_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_phase_reg |-> (s1_valid_reg && s1_dbl_reg))
        else $error("doubling phase set without a doubled pixel held");

    // first write of a doubled pixel is followed by its partner
    a_dbl_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && s1_dbl_reg && !s1_phase_reg) |=> (s1_valid_reg && s1_phase_reg))
        else $error("doubled pixel lost its second write");

    // palette colour must not move while its pixel still owes writes
    a_colour_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_phase_reg |-> $stable(pal_rd_data))
        else $error("palette read data moved under a held pixel");

    // every write lands inside the output line
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CMP_W'(m_column) < CMP_W'(OUT_WIDTH)))
        else $error("column beyond output width");

    // an intermediate write is always followed by the final one
    a_last_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && m_last))
        else $error("missing final write of a doubled pixel");
`endif

endmodule

/* rtl/pls_palette_ram.sv */
// ============================================================================
// pls_palette_ram: palette store
// 256 x 16 single-port-write memory, registered read.
// ============================================================================
module pls_palette_ram (
    input  logic                               aclk,
    input  pls_pkg::pal_wr_t                   wr,
    input  logic                               rd_en,
    input  logic [pls_pkg::PAL_ADDR_W-1:0]     rd_addr,
    output logic [pls_pkg::COLOR_W-1:0]        rd_data
);
    import pls_pkg::*;

    logic [COLOR_W-1:0] mem [PAL_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: palette line scaler
// Drives palette writes and source pixels through the s_ channel, programs
// the line width and palette mode over APB between phases, and checks every
// frame-buffer write in order against typed table rows or an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
    import pls_pkg::*;

    typedef enum logic {
        KIND_PALETTE = 1'b0,
        KIND_PIXEL   = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic                first;
        logic [LINE_W-1:0]   line;
        logic [7:0]          slot;
        logic [COLOR_W-1:0]  pixel;
    } src_item_t;

    typedef struct packed {
        logic [BLK_W-1:0]    blk;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } fb_write_t;

    // directed rows: an item, or a register write whose value sits in pixel
    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_WIDTH,
        ROW_SET_PALETTE
    } row_op_t;

    typedef struct packed {
        row_op_t    op;
        src_item_t  item;
        logic       typed;      // 1: expected writes below, else the model decides
        logic [1:0] n_typed;
        fb_write_t  w0;
        fb_write_t  w1;
    } dir_row_t;

    localparam fb_write_t NO_WR = '0;
    localparam int DIR_ROWS = 30;
    localparam int DRAIN_CYCLES = 8;           // margin past the pipeline
    localparam int IDLE_SWITCH = 530;          // items per idling regime
    localparam int WATCHDOG_NS = 3_000_000;

    // Reset state: width 320 (plain copy), palette lookup on.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // palette extremes; first and line are don't-care on a palette write
        '{ROW_ITEM, '{KIND_PALETTE, 1'b0, 8'd0, 8'h00, 16'hFFFF}, 1'b1, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PALETTE, 1'b0, 8'd0, 8'hFF, 16'h0000}, 1'b1, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PALETTE, 1'b0, 8'd0, 8'h5A, 16'h1234}, 1'b1, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PALETTE, 1'b1, 8'd255, 8'hA5, 16'h8001}, 1'b1, 2'd0, NO_WR, NO_WR},
        // pixels straight out of reset, no line start: line 0, column from 0
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd200, 8'h00, 16'h0000}, 1'b1, 2'd1,
          '{2'd0, 6'd0, 9'd0, 16'hFFFF, 1'b1}, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd55, 8'hFF, 16'hFFFF}, 1'b1, 2'd1,
          '{2'd0, 6'd0, 9'd1, 16'h0000, 1'b1}, NO_WR},
        // last visible line, then lines below the frame give nothing
        '{ROW_ITEM, '{KIND_PIXEL, 1'b1, 8'd239, 8'h00, 16'hAB5A}, 1'b1, 2'd1,
          '{2'd3, 6'd47, 9'd0, 16'h1234, 1'b1}, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd0, 8'h33, 16'h00A5}, 1'b1, 2'd1,
          '{2'd3, 6'd47, 9'd1, 16'h8001, 1'b1}, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b1, 8'd240, 8'h00, 16'h0000}, 1'b1, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b1, 8'd255, 8'h00, 16'h0000}, 1'b1, 2'd0, NO_WR, NO_WR},
        // direct colour, pixel doubling
        '{ROW_SET_PALETTE, '{KIND_PIXEL, 1'b0, 8'd0, 8'd0, 16'd0}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_SET_WIDTH, '{KIND_PIXEL, 1'b0, 8'd0, 8'd0, 16'd160}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b1, 8'd64, 8'h00, 16'hBEEF}, 1'b1, 2'd2,
          '{2'd1, 6'd0, 9'd0, 16'hBEEF, 1'b0}, '{2'd1, 6'd0, 9'd1, 16'hBEEF, 1'b1}},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd0, 8'h00, 16'h0000}, 1'b1, 2'd2,
          '{2'd1, 6'd0, 9'd2, 16'h0000, 1'b0}, '{2'd1, 6'd0, 9'd3, 16'h0000, 1'b1}},
        // palette mode switched mid-line: applies from the next pixel
        '{ROW_SET_PALETTE, '{KIND_PIXEL, 1'b0, 8'd0, 8'd0, 16'd1}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd9, 8'h00, 16'h005A}, 1'b1, 2'd2,
          '{2'd1, 6'd0, 9'd4, 16'h1234, 1'b0}, '{2'd1, 6'd0, 9'd5, 16'h1234, 1'b1}},
        // widest source line: nearest-neighbour downscale
        '{ROW_SET_WIDTH, '{KIND_PIXEL, 1'b0, 8'd0, 8'd0, 16'd1023}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b1, 8'd127, 8'h00, 16'hFFFF}, 1'b1, 2'd1,
          '{2'd1, 6'd63, 9'd0, 16'h0000, 1'b1}, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd0, 8'h00, 16'h0000}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd0, 8'h00, 16'h005A}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd0, 8'h00, 16'h00A5}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd0, 8'h00, 16'h0000}, 1'b0, 2'd0, NO_WR, NO_WR},
        // empty line
        '{ROW_SET_WIDTH, '{KIND_PIXEL, 1'b0, 8'd0, 8'd0, 16'd0}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b1, 8'd10, 8'h00, 16'h0000}, 1'b1, 2'd0, NO_WR, NO_WR},
        // one-pixel line, centred; second pixel is past the source width
        '{ROW_SET_WIDTH, '{KIND_PIXEL, 1'b0, 8'd0, 8'd0, 16'd1}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b1, 8'd128, 8'h00, 16'h00A5}, 1'b1, 2'd1,
          '{2'd2, 6'd0, 9'd159, 16'h8001, 1'b1}, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd0, 8'h00, 16'h00A5}, 1'b1, 2'd0, NO_WR, NO_WR},
        // just over the output width: step rounds down to one
        '{ROW_SET_WIDTH, '{KIND_PIXEL, 1'b0, 8'd0, 8'd0, 16'd321}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b1, 8'd191, 8'h00, 16'h005A}, 1'b0, 2'd0, NO_WR, NO_WR},
        '{ROW_ITEM, '{KIND_PIXEL, 1'b0, 8'd0, 8'h00, 16'hFFFF}, 1'b0, 2'd0, NO_WR, NO_WR}
    };

    // ------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_kind = 1'b0;
    logic                  s_first = 1'b0;
    logic [LINE_W-1:0]     s_line = '0;
    logic [PAL_ADDR_W-1:0] s_palette_slot = '0;
    logic [COLOR_W-1:0]    s_pixel = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BLK_W-1:0]      m_frame_block;
    logic [ROW_W-1:0]      m_block_row;
    logic [COL_W-1:0]      m_column;
    logic [COLOR_W-1:0]    m_color;
    logic                  m_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    palette_line_scaler u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scaler model state: palette, line position, register copies
    // ------------------------------------------------------------------------
    logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
    bit                 pal_valid [PAL_DEPTH];
    logic [7:0]         written_slots [$];     // slots safe to look up
    logic [SRC_W-1:0]   src_pos = '0;
    logic [COL_W-1:0]   dst_col = '0;
    logic [POS_W-1:0]   scale_acc = '0;
    logic [LINE_W-1:0]  line_cur = '0;
    logic [SRC_W-1:0]   cfg_width = SRC_W'(320);
    logic               cfg_use_pal = 1'b1;

    fb_write_t fb_expected [$];               // writes still owed by the block
    fb_write_t fb_want;
    int        fail_count = 0;
    int        items_sent = 0;
    int        send_idle_pct = 16;
    int        recv_idle_pct = 62;

    // Advances the model by one accepted item; returns how many frame-buffer
    // writes it owes (0..2) in w0/w1.
    function automatic int predict_writes(input src_item_t it,
                                          output fb_write_t w0, output fb_write_t w1);
        logic [SRC_W-1:0]   s;
        logic [POS_W-1:0]   step;
        fb_write_t          w;
        w0 = '0;
        w1 = '0;
        if (it.kind == KIND_PALETTE) begin
            pal_mem[it.slot] = it.pixel;
            if (!pal_valid[it.slot]) begin
                pal_valid[it.slot] = 1'b1;
                written_slots.push_back(it.slot);
            end
            return 0;
        end
        if (it.first) begin
            src_pos   = '0;
            dst_col   = '0;
            scale_acc = '0;
            line_cur  = it.line;
        end
        s = src_pos;
        if (src_pos != SRC_COUNT_MAX)       // saturates rather than wrapping
            src_pos = src_pos + SRC_W'(1);
        if (s >= cfg_width || int'(line_cur) >= OUT_HEIGHT)
            return 0;

        w.blk   = BLK_W'(int'(line_cur) / BLOCK_ROWS);
        w.row   = ROW_W'(int'(line_cur) % BLOCK_ROWS);
        w.color = cfg_use_pal ? pal_mem[it.pixel[7:0]] : it.pixel;
        w.last  = 1'b1;
        w.col   = '0;

        if (int'(cfg_width) > OUT_WIDTH) begin
            // 10.8 step, truncated; a write whenever the integer part lands on s
            step = POS_W'((int'(cfg_width) * 256) / OUT_WIDTH);
            if (int'(dst_col) < OUT_WIDTH && scale_acc[POS_W-1:8] == s) begin
                w.col     = dst_col;
                w0        = w;
                dst_col   = dst_col + COL_W'(1);
                scale_acc = scale_acc + step;
                return 1;
            end
            return 0;
        end else if (int'(cfg_width) * 2 == OUT_WIDTH) begin
            w.col  = COL_W'(2 * int'(s));
            w.last = 1'b0;
            w0     = w;
            w.col  = COL_W'(2 * int'(s) + 1);
            w.last = 1'b1;
            w1     = w;
            return 2;
        end
        w.col = COL_W'((OUT_WIDTH - int'(cfg_width)) / 2 + int'(s));
        w0    = w;
        return 1;
    endfunction

    // ------------------------------------------------------------------------
    // Source channel
    // ------------------------------------------------------------------------
    // One transfer. Typed rows override the model's writes but still move
    // its state on.
    task automatic send_item(input src_item_t it, input bit typed = 1'b0,
                             input int n_typed = 0,
                             input fb_write_t t0 = '0, input fb_write_t t1 = '0);
        fb_write_t w0, w1;
        int        n;
        case (items_sent / IDLE_SWITCH)
            0: begin
                send_idle_pct = 16;
                recv_idle_pct = 62;
            end
            1: begin
                send_idle_pct = 62;
                recv_idle_pct = 16;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= it.kind;
        s_first        <= it.first;
        s_line         <= it.line;
        s_palette_slot <= it.slot;
        s_pixel        <= it.pixel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        n = predict_writes(it, w0, w1);
        if (typed) begin
            n  = n_typed;
            w0 = t0;
            w1 = t1;
        end
        if (n > 0) fb_expected.push_back(w0);
        if (n > 1) fb_expected.push_back(w1);
    endtask

    // Sender holds off until every owed write is out, plus the pipeline depth
    // for items that owe nothing.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (fb_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic src_item_t rand_palette_write();
        src_item_t it;
        it       = src_item_t'({$urandom, $urandom});
        it.kind  = KIND_PALETTE;
        return it;
    endfunction

    // With lookup on, the index byte only ever names a slot already loaded.
    function automatic src_item_t rand_pixel(input logic first, input logic [LINE_W-1:0] ln);
        src_item_t it;
        it       = src_item_t'({$urandom, $urandom});
        it.kind  = KIND_PIXEL;
        it.first = first;
        it.line  = ln;
        if (cfg_use_pal)
            it.pixel[7:0] = written_slots[$urandom_range(0, written_slots.size() - 1)];
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // APB: write, then read back the register's bits
    // ------------------------------------------------------------------------
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_SOURCE_WIDTH) begin
            if (prdata[SRC_W-1:0] !== value[SRC_W-1:0]) begin
                $error("source_width readback: expected %0d, got %0d",
                       value[SRC_W-1:0], prdata[SRC_W-1:0]);
                fail_count++;
            end
            cfg_width = value[SRC_W-1:0];
        end else begin
            if (prdata[0] !== value[0]) begin
                $error("use_palette readback: expected %0d, got %0d", value[0], prdata[0]);
                fail_count++;
            end
            cfg_use_pal = value[0];
        end
    endtask

    task automatic set_mode(input int width, input bit use_pal);
        drain_results();
        write_reg(REG_SOURCE_WIDTH, 32'(width));
        write_reg(REG_USE_PALETTE, 32'(use_pal));
    endtask

    // Random lines: mostly well-formed runs from a line start, some at or
    // just past the full width, with palette writes, lines that never got a
    // start, stray restarts and lines below the frame mixed in.
    task automatic run_lines(input int budget);
        int                left, len, k;
        bit                open_first;
        logic [LINE_W-1:0] line_no;
        left = budget;
        while (left > 0) begin
            len = ($urandom_range(0, 7) == 0) ? int'(cfg_width) + int'($urandom_range(0, 3))
                                              : int'($urandom_range(1, 20));
            open_first = ($urandom_range(0, 15) != 0);
            line_no = ($urandom_range(0, 7) == 0) ? LINE_W'($urandom_range(240, 255))
                                                  : LINE_W'($urandom_range(0, 239));
            for (k = 0; k < len && left > 0; k++) begin
                if ($urandom_range(0, 99) < 12)
                    send_item(rand_palette_write());
                else if (k == 0)
                    send_item(rand_pixel(open_first, line_no));
                else
                    send_item(rand_pixel($urandom_range(0, 63) == 0, LINE_W'($urandom)));
                left--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result channel: check each transfer against the oldest owed write,
    // then pick the next ready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (fb_expected.size() == 0) begin
                $error("frame-buffer write with none owed: column %0d, color %h",
                       m_column, m_color);
                fail_count++;
            end else begin
                fb_want = fb_expected.pop_front();
                if (m_frame_block !== fb_want.blk) begin
                    $error("frame_block: expected %0d, got %0d", fb_want.blk, m_frame_block);
                    fail_count++;
                end
                if (m_block_row !== fb_want.row) begin
                    $error("block_row: expected %0d, got %0d", fb_want.row, m_block_row);
                    fail_count++;
                end
                if (m_column !== fb_want.col) begin
                    $error("column: expected %0d, got %0d", fb_want.col, m_column);
                    fail_count++;
                end
                if (m_color !== fb_want.color) begin
                    $error("color: expected %h, got %h", fb_want.color, m_color);
                    fail_count++;
                end
                if (m_last !== fb_want.last) begin
                    $error("last: expected %0d, got %0d", fb_want.last, m_last);
                    fail_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int       i, ph, pix;
        dir_row_t r;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; register rows wait for the block to go quiet
        for (i = 0; i < DIR_ROWS; i++) begin
            r = DIR_TABLE[i];
            case (r.op)
                ROW_SET_WIDTH: begin
                    drain_results();
                    write_reg(REG_SOURCE_WIDTH, 32'(r.item.pixel));
                end
                ROW_SET_PALETTE: begin
                    drain_results();
                    write_reg(REG_USE_PALETTE, 32'(r.item.pixel));
                end
                default: send_item(r.item, r.typed, int'(r.n_typed), r.w0, r.w1);
            endcase
        end

        // random phases, one width regime each
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    set_mode(320, 1'b1);
                    run_lines(130);
                end
                1: begin
                    set_mode(160, 1'b0);
                    run_lines(130);
                end
                2: begin
                    set_mode($urandom_range(1, 40), 1'b1);
                    run_lines(130);
                end
                3: begin
                    // one full line at the widest source, run past 1024
                    // pixels so the source counter has to saturate
                    set_mode(1023, 1'($urandom_range(0, 1)));
                    send_item(rand_pixel(1'b1, LINE_W'($urandom_range(0, 239))));
                    for (pix = 1; pix < 1030; pix++)
                        send_item(rand_pixel(1'b0, LINE_W'($urandom)));
                end
                4: begin
                    set_mode($urandom_range(321, 1022), 1'b0);
                    run_lines(80);
                end
                default: begin
                    set_mode($urandom_range(0, 1023), 1'($urandom_range(0, 1)));
                    run_lines(60);
                end
            endcase
        end

        drain_results();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard
    initial begin
        #(WATCHDOG_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
